// ===== rtl/bpe_pkg.sv =====
// bpe_pkg: shared widths, curve constants and payload types of the battery percent estimator
// no dependencies; used by the channel interfaces, bpe_curve and battery_percent_estimator
`default_nettype none

package bpe_pkg;

    localparam int ADC_W       = 10;
    localparam int MV_W        = 13;
    localparam int PCT_W       = 7;
    localparam int OFS_W       = 8;   // offset inside one curve segment, widest segment is 203 mV
    localparam int COEF_W      = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int NUM_PTS     = 6;
    localparam int NUM_SEG     = NUM_PTS - 1;

    // mv = sample * 4800 / 1024 = sample * 75 / 16
    localparam int MV_MUL      = 4800 / 64;
    localparam int MV_SHIFT    = 4;
    localparam int MV_PROD_W   = ADC_W + 7;

    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] PCT_CHG_CAP = 7'd99;
    localparam logic [PCT_W-1:0] PCT_EMPTY   = 7'd0;

    localparam logic [MV_W-1:0] CURVE_MV [0:NUM_PTS-1] = '{
        13'd3500, 13'd3616, 13'd3723, 13'd3776, 13'd3979, 13'd4180
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [0:NUM_PTS-1] = '{
        7'd0, 7'd3, 7'd22, 7'd48, 7'd79, 7'd100
    };

    // slope dy/dx as ceil(dy * 2^16 / dx); exact floor for every offset below dx
    localparam int COEF_0 = ((3  << RECIP_SHIFT) + 116 - 1) / 116;
    localparam int COEF_1 = ((19 << RECIP_SHIFT) + 107 - 1) / 107;
    localparam int COEF_2 = ((26 << RECIP_SHIFT) + 53  - 1) / 53;
    localparam int COEF_3 = ((31 << RECIP_SHIFT) + 203 - 1) / 203;
    localparam int COEF_4 = ((21 << RECIP_SHIFT) + 201 - 1) / 201;

    localparam logic [COEF_W-1:0] SEG_COEF [0:NUM_SEG-1] = '{
        COEF_W'(COEF_0), COEF_W'(COEF_1), COEF_W'(COEF_2), COEF_W'(COEF_3), COEF_W'(COEF_4)
    };

    typedef struct packed {
        logic [ADC_W-1:0] adc_sample;
        logic             charging_active;
        logic             power_present;
    } t_bpe_in;

    typedef struct packed {
        logic [MV_W-1:0]  voltage_mv;
        logic [PCT_W-1:0] percent_remaining;
        logic             percent_updated;
        logic             is_charging;
        logic             full_flag_out;
    } t_bpe_out;

    // segment selection handed from the curve stage to the interpolation stage
    typedef struct packed {
        logic [MV_W-1:0]   mv;
        logic [OFS_W-1:0]  ofs;
        logic [PCT_W-1:0]  y0;
        logic [COEF_W-1:0] coef;
    } t_bpe_seg;

endpackage

`default_nettype wire

// ===== rtl/bpe_in_if.sv =====
// bpe_in_if: valid/ready channel carrying one battery measurement request
// depends on bpe_pkg for the payload type
`default_nettype none

interface bpe_in_if;
    logic               valid;
    logic               ready;
    bpe_pkg::t_bpe_in   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpe_out_if.sv =====
// bpe_out_if: valid/ready channel carrying one state-of-charge result request
// depends on bpe_pkg for the payload type
`default_nettype none

interface bpe_out_if;
    logic               valid;
    logic               ready;
    bpe_pkg::t_bpe_out  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpe_curve.sv =====
// bpe_curve: sample to millivolt scaling and piecewise-linear segment selection
// depends on bpe_pkg; purely combinational, registered by the top level
`default_nettype none

module bpe_curve (
    input  wire logic [bpe_pkg::ADC_W-1:0] i_sample,
    output bpe_pkg::t_bpe_seg              o_seg
);

    logic [bpe_pkg::MV_PROD_W-1:0] mv_prod;
    logic [bpe_pkg::MV_W-1:0]      mv;

    always_comb begin
        mv_prod = bpe_pkg::MV_PROD_W'(i_sample) * bpe_pkg::MV_PROD_W'(bpe_pkg::MV_MUL);
        mv      = bpe_pkg::MV_W'(mv_prod >> bpe_pkg::MV_SHIFT);

        // at or above the top point: flat at the last percent
        o_seg.mv   = mv;
        o_seg.ofs  = '0;
        o_seg.y0   = bpe_pkg::CURVE_PCT[bpe_pkg::NUM_PTS-1];
        o_seg.coef = '0;

        // walk down so the lowest matching segment wins
        for (int k = bpe_pkg::NUM_PTS - 1; k >= 1; k--) begin
            if (mv < bpe_pkg::CURVE_MV[k]) begin
                o_seg.ofs  = bpe_pkg::OFS_W'(mv - bpe_pkg::CURVE_MV[k-1]);
                o_seg.y0   = bpe_pkg::CURVE_PCT[k-1];
                o_seg.coef = bpe_pkg::SEG_COEF[k-1];
            end
        end

        // below the bottom point: empty
        if (mv < bpe_pkg::CURVE_MV[0]) begin
            o_seg.ofs  = '0;
            o_seg.y0   = bpe_pkg::CURVE_PCT[0];
            o_seg.coef = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/battery_percent_estimator.sv =====
// battery_percent_estimator: top level, three register stages plus the charge state
// depends on bpe_pkg, bpe_in_if, bpe_out_if and bpe_curve
`default_nettype none

// Usage
// - i_in carries one measurement request: 10-bit converter sample, charging level and
//   power-present level. o_out carries one result request for every measurement: voltage in
//   mV, stored percent, update flag, charging indication and sticky full flag.
// - a request is taken at a rising edge with valid and ready both high on a channel
// - a taken measurement passes through the input register, loaded on the edge that takes
//   it, then the segment register, then the result register, where its result becomes valid
// - throughput: one measurement per cycle while the receiver keeps o_out.ready high; the
//   single multiply of the interpolation and the full flag / stored percent update sit in
//   the last stage, so back-to-back measurements see the state left by the one before
// - receiver stall: each stage holds its request while the next one is full; bubbles
//   are squeezed out, so two more measurements can be taken while a result waits, three
//   in flight in all before i_in.ready drops
// - reset (synchronous, active low) empties the pipeline, clears the full flag and the stored
//   percent and marks the next measurement as the first, which always loads the percent
// - scaling is sample * 4800 / 1024 truncated; the percent follows a six-point curve
//   between 3500 and 4180 mV, is 100 once full and is otherwise capped at 99 while charging

module battery_percent_estimator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpe_in_if.sink     i_in,
    bpe_out_if.source  o_out
);

    // stage enables, each stage moves when it is empty or its successor moves
    logic en_out;
    logic en_b;
    logic en_a;

    // input register
    logic              r_a_valid;
    bpe_pkg::t_bpe_in  r_a_data;

    // segment register
    logic              r_b_valid;
    bpe_pkg::t_bpe_seg r_b_seg;
    logic              r_b_chg;
    logic              r_b_pwr;

    // result register
    logic              r_out_valid;
    bpe_pkg::t_bpe_out r_out_data;

    // charge state
    logic                      r_full;
    logic [bpe_pkg::PCT_W-1:0] r_stored;
    logic                      r_first;

    bpe_pkg::t_bpe_seg seg;

    logic [bpe_pkg::OFS_W+bpe_pkg::COEF_W-1:0] prod;
    logic [bpe_pkg::PCT_W-1:0]                 interp;
    logic [bpe_pkg::PCT_W-1:0]                 cap;
    logic [bpe_pkg::PCT_W-1:0]                 cand;
    logic                                      n_full;
    logic                                      do_update;
    logic                                      step;
    bpe_pkg::t_bpe_out                         n_out_data;

    assign en_out = !r_out_valid || o_out.ready;
    assign en_b   = !r_b_valid || en_out;
    assign en_a   = !r_a_valid || en_b;
    assign step   = r_b_valid && en_out;

    assign i_in.ready  = en_a;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    bpe_curve u_curve (
        .i_sample (r_a_data.adc_sample),
        .o_seg    (seg)
    );

    // interpolation, capping and the state update for the measurement in the segment stage
    always_comb begin
        prod   = bpe_pkg::OFS_W'(r_b_seg.ofs) * r_b_seg.coef;
        interp = r_b_seg.y0
               + bpe_pkg::PCT_W'(prod[bpe_pkg::OFS_W+bpe_pkg::COEF_W-1:bpe_pkg::RECIP_SHIFT]);

        // sticky full: set on supply without charging, dropped when supply goes away
        priority if (r_b_pwr && !r_b_chg) begin
            n_full = 1'b1;
        end else if (!r_b_pwr) begin
            n_full = 1'b0;
        end else begin
            n_full = r_full;
        end

        cap = r_b_chg ? bpe_pkg::PCT_CHG_CAP : bpe_pkg::PCT_FULL;
        if (n_full) begin
            cand = bpe_pkg::PCT_FULL;
        end else if (interp > cap) begin
            cand = cap;
        end else begin
            cand = interp;
        end

        // percent only rises on supply and only falls on battery; first one always loads
        do_update = r_first
                 || ( r_b_pwr && (cand > r_stored))
                 || (!r_b_pwr && (cand < r_stored));

        n_out_data.voltage_mv        = r_b_seg.mv;
        n_out_data.percent_remaining = do_update ? cand : r_stored;
        n_out_data.percent_updated   = do_update;
        n_out_data.is_charging       = r_b_chg && !n_full;
        n_out_data.full_flag_out     = n_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_full      <= 1'b0;
            r_stored    <= bpe_pkg::PCT_EMPTY;
            r_first     <= 1'b1;
        end else begin
            if (en_a) begin
                r_a_valid <= i_in.valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (en_out) begin
                r_out_valid <= r_b_valid;
            end
            if (step) begin
                r_full   <= n_full;
                r_stored <= n_out_data.percent_remaining;
                r_first  <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (en_a && i_in.valid) begin
            r_a_data <= i_in.data;
        end
        if (en_b && r_a_valid) begin
            r_b_seg <= seg;
            r_b_chg <= r_a_data.charging_active;
            r_b_pwr <= r_a_data.power_present;
        end
        if (step) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_battery_percent_estimator.sv =====
// tb_battery_percent_estimator: self-checking bench for the battery percent estimator
// depends on bpe_pkg, bpe_in_if, bpe_out_if and the battery_percent_estimator rtl
`timescale 1ns / 100ps

module tb_battery_percent_estimator;

    localparam int          RAND_ITEMS  = 1000;
    localparam int          HOLD_CYCLES = 60;     // long receiver hold-off, fills the pipe
    localparam int          IDLE_LIMIT  = 2000;   // cycles without any request moving
    localparam int          MAX_SHOWN   = 10;
    localparam int          NUM_KNEE    = 6;
    localparam int          NUM_ROWS    = 24;

    // discharge curve knees, millivolts and percent
    localparam int unsigned KNEE_MV  [NUM_KNEE] = '{3500, 3616, 3723, 3776, 3979, 4180};
    localparam int unsigned KNEE_PCT [NUM_KNEE] = '{0, 3, 22, 48, 79, 100};
    localparam int unsigned PCT_MAX_CHG = 99;
    localparam int unsigned PCT_TOP     = 100;

    typedef struct packed {
        bpe_pkg::t_bpe_in  req;
        logic              typed;    // expected result written out below
        bpe_pkg::t_bpe_out res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpe_in_if  in_ch ();
    bpe_out_if out_ch ();

    battery_percent_estimator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predicted charge state
    logic                      soc_full;
    logic [bpe_pkg::PCT_W-1:0] soc_pct;
    logic                      soc_first;

    bpe_pkg::t_bpe_out soc_expected [$];
    bpe_pkg::t_bpe_out soc_want;
    int       n_mismatch = 0;
    int       n_taken    = 0;
    int       idle_cycles = 0;
    int       send_burst = 0;
    bit       hold_req   = 1'b0;

    // directed rows: typed where the answer is obvious, the rest goes through the predictor
    t_dir_row dir_rows [NUM_ROWS] = '{
        // first measurement after reset always loads, empty battery
        '{'{10'd0,    1'b0, 1'b0}, 1'b1, '{13'd0,    7'd0,   1'b1, 1'b0, 1'b0}},
        // full-scale sample while unplugged: higher percent is ignored
        '{'{10'd1023, 1'b0, 1'b0}, 1'b1, '{13'd4795, 7'd0,   1'b0, 1'b0, 1'b0}},
        // plugged and charging at top voltage: capped at 99
        '{'{10'd1023, 1'b1, 1'b1}, 1'b1, '{13'd4795, 7'd99,  1'b1, 1'b1, 1'b0}},
        // plugged, charger done: full flag sets, 100 regardless of voltage
        '{'{10'd0,    1'b0, 1'b1}, 1'b1, '{13'd0,    7'd100, 1'b1, 1'b0, 1'b1}},
        // charging again while full: flag sticks, no charging indication
        '{'{10'd0,    1'b1, 1'b1}, 1'b1, '{13'd0,    7'd100, 1'b0, 1'b0, 1'b1}},
        // unplug clears full, charging level without power still caps at 99
        '{'{10'd1023, 1'b1, 1'b0}, 1'b1, '{13'd4795, 7'd99,  1'b1, 1'b1, 1'b0}},
        '{'{10'd0,    1'b0, 1'b0}, 1'b1, '{13'd0,    7'd0,   1'b1, 1'b0, 1'b0}},
        // climb through every knee while charging
        '{'{10'd746,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd747,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd772,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd795,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd806,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd849,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd891,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd892,  1'b1, 1'b1}, 1'b0, '0},
        // discharge downward through the segments
        '{'{10'd870,  1'b0, 1'b0}, 1'b0, '0},
        '{'{10'd830,  1'b0, 1'b0}, 1'b0, '0},
        '{'{10'd800,  1'b0, 1'b0}, 1'b0, '0},
        '{'{10'd780,  1'b0, 1'b0}, 1'b0, '0},
        '{'{10'd760,  1'b0, 1'b0}, 1'b0, '0},
        '{'{10'd512,  1'b1, 1'b0}, 1'b0, '0},
        '{'{10'd682,  1'b0, 1'b1}, 1'b0, '0},
        '{'{10'd341,  1'b1, 1'b1}, 1'b0, '0},
        '{'{10'd900,  1'b1, 1'b0}, 1'b0, '0}
    };

    // truncating interpolation on the knee table, clamped at both ends
    function automatic int unsigned curve_percent(input int unsigned mv);
        int unsigned pct;
        pct = KNEE_PCT[NUM_KNEE-1];
        if (mv < KNEE_MV[0]) begin
            pct = KNEE_PCT[0];
        end
        for (int i = 1; i < NUM_KNEE; i++) begin
            if (mv >= KNEE_MV[i-1] && mv < KNEE_MV[i]) begin
                pct = KNEE_PCT[i-1] + ((mv - KNEE_MV[i-1]) * (KNEE_PCT[i] - KNEE_PCT[i-1]))
                      / (KNEE_MV[i] - KNEE_MV[i-1]);
            end
        end
        return pct;
    endfunction

    // advances the predicted charge state by one measurement and returns its result
    function automatic bpe_pkg::t_bpe_out predict_soc(input bpe_pkg::t_bpe_in req);
        int unsigned       sample;
        int unsigned       mv;
        int unsigned       pct;
        bpe_pkg::t_bpe_out res;
        if (req.power_present && !req.charging_active) begin
            soc_full = 1'b1;
        end else if (!req.power_present) begin
            soc_full = 1'b0;
        end
        sample = 32'(req.adc_sample);
        mv     = (sample * 4800) / 1024;
        pct    = PCT_TOP;
        if (!soc_full) begin
            pct = curve_percent(mv);
            if (req.charging_active && pct > PCT_MAX_CHG) begin
                pct = PCT_MAX_CHG;
            end
        end
        res.percent_updated = 1'b0;
        // rises only on power, falls only on battery, first one always loads
        if (soc_first || (req.power_present && pct > soc_pct)
                || (!req.power_present && pct < soc_pct)) begin
            soc_first           = 1'b0;
            soc_pct             = bpe_pkg::PCT_W'(pct);
            res.percent_updated = 1'b1;
        end
        res.voltage_mv        = bpe_pkg::MV_W'(mv);
        res.percent_remaining = soc_pct;
        res.is_charging       = req.charging_active && !soc_full;
        res.full_flag_out     = soc_full;
        return res;
    endfunction

    // offers one measurement request after a random gap, records the expectation on acceptance
    task automatic offer_meas(input bpe_pkg::t_bpe_in req, input logic typed,
                              input bpe_pkg::t_bpe_out typed_res);
        int unsigned       gap;
        bpe_pkg::t_bpe_out want;
        if (send_burst != 0) begin
            send_burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 31) == 0) begin
                send_burst = 40;
            end
        end
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= req;
        do @(posedge i_clk); while (!in_ch.ready);
        want = predict_soc(req);
        if (typed) begin
            want = typed_res;
        end
        soc_expected.push_back(want);
        n_taken++;
        // ask the receiver to sit still for a while so the pipe backs up
        if (n_taken == 250 || n_taken == 750) begin
            hold_req = 1'b1;
        end
        @(negedge i_clk);
    endtask

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (soc_expected.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_SHOWN) begin
                        $display("unexpected result request: mv=%0d pct=%0d upd=%0b chg=%0b full=%0b",
                                 out_ch.data.voltage_mv, out_ch.data.percent_remaining,
                                 out_ch.data.percent_updated, out_ch.data.is_charging,
                                 out_ch.data.full_flag_out);
                    end
                end else begin
                    soc_want = soc_expected.pop_front();
                    if (out_ch.data.voltage_mv !== soc_want.voltage_mv
                            || out_ch.data.percent_remaining !== soc_want.percent_remaining
                            || out_ch.data.percent_updated !== soc_want.percent_updated
                            || out_ch.data.is_charging !== soc_want.is_charging
                            || out_ch.data.full_flag_out !== soc_want.full_flag_out) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_SHOWN) begin
                            $display("mismatch: exp mv=%0d pct=%0d upd=%0b chg=%0b full=%0b",
                                     soc_want.voltage_mv, soc_want.percent_remaining,
                                     soc_want.percent_updated, soc_want.is_charging,
                                     soc_want.full_flag_out);
                            $display("          got mv=%0d pct=%0d upd=%0b chg=%0b full=%0b",
                                     out_ch.data.voltage_mv, out_ch.data.percent_remaining,
                                     out_ch.data.percent_updated, out_ch.data.is_charging,
                                     out_ch.data.full_flag_out);
                        end
                    end
                end
            end
        end
    end

    // result side: random stalls, idle-free stretches and the occasional long hold-off
    initial begin : result_sink
        int unsigned stall;
        int unsigned rx_burst;
        rx_burst     = 0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else if (rx_burst != 0) begin
                rx_burst--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 31) == 0) begin
                    rx_burst = 40;
                end
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    // measurement side: reset, directed rows, then random noise bursts and charge and discharge episodes
    initial begin : meas_source
        bpe_pkg::t_bpe_in req;
        int      n_rand;
        int      ep_len;
        int      level;
        int      step;
        logic    pwr;
        logic    chg;
        soc_full    = 1'b0;
        soc_pct     = '0;
        soc_first   = 1'b1;
        n_rand      = 0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            offer_meas(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].res);
        end

        while (n_rand < RAND_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                // noise: any field value at all
                ep_len = $urandom_range(1, 8);
                for (int k = 0; k < ep_len; k++) begin
                    req.adc_sample      = bpe_pkg::ADC_W'($urandom_range(0, 1023));
                    req.charging_active = 1'($urandom_range(0, 1));
                    req.power_present   = 1'($urandom_range(0, 1));
                    offer_meas(req, 1'b0, '0);
                    n_rand++;
                end
            end else begin
                // a plugged-in charge or a battery discharge with voltage drifting
                pwr    = 1'($urandom_range(0, 1));
                chg    = pwr ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
                level  = pwr ? $urandom_range(730, 860) : $urandom_range(790, 910);
                ep_len = $urandom_range(4, 32);
                for (int k = 0; k < ep_len; k++) begin
                    step  = $urandom_range(0, 4);
                    level = pwr ? level + step : level - step;
                    if (level > 1023) level = 1023;
                    if (level < 0) level = 0;
                    // charger finishing or restarting mid-episode
                    if ($urandom_range(0, 15) == 0) begin
                        chg = !chg;
                    end
                    req.adc_sample      = level[bpe_pkg::ADC_W-1:0];
                    req.charging_active = chg;
                    req.power_present   = pwr;
                    offer_meas(req, 1'b0, '0);
                    n_rand++;
                end
            end
        end
        in_ch.valid <= 1'b0;

        while (soc_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0 && soc_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpe_pkg.sv
rtl/bpe_in_if.sv
rtl/bpe_out_if.sv
rtl/bpe_curve.sv
rtl/battery_percent_estimator.sv
verif/tb_battery_percent_estimator.sv
